/* rtl/core/smf_pkg.sv */
package smf_pkg;

  // history size and the counter that walks it
  localparam int HISTORY_DEPTH = 64;
  localparam int CNT_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  localparam int KEY_W   = 64;
  localparam int NONCE_W = 32;

  // one message key
  typedef struct packed {
    logic [KEY_W-1:0]   sender_key;
    logic [NONCE_W-1:0] message_nonce;
  } pair_t;

  // stored history entry, shifted from cell to cell on insert
  typedef struct packed {
    pair_t pair;
    logic  valid;
  } entry_t;

  // lookup token, moves one cell per cycle and collects the hit
  typedef struct packed {
    pair_t pair;
    logic  hit;
  } probe_t;

endpackage

/* rtl/core/smf_msg_if.sv */
interface smf_msg_if;
  import smf_pkg::*;

  logic               valid;
  logic               ready;
  logic [KEY_W-1:0]   sender_key;
  logic [NONCE_W-1:0] message_nonce;

  modport source (output valid, output sender_key, output message_nonce, input ready);
  modport sink   (input valid, input sender_key, input message_nonce, output ready);
endinterface

/* rtl/core/smf_verdict_if.sv */
interface smf_verdict_if;
  logic valid;
  logic ready;
  logic duplicate;

  modport source (output valid, output duplicate, input ready);
  modport sink   (input valid, input duplicate, output ready);
endinterface

/* rtl/core/smf_cell.sv */
module smf_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  smf_pkg::entry_t entry_in,
  output smf_pkg::entry_t entry_out,
  input  smf_pkg::probe_t probe_in,
  output smf_pkg::probe_t probe_out
);
  import smf_pkg::*;

  pair_t  pair;
  logic   valid;
  probe_t probe;
  logic   match;

  // local compare against the stored entry
  assign match = valid && (pair == probe_in.pair);

  // stored entry: takes the neighbor's entry on insert
  always_ff @(posedge clk) begin
    if (shift) begin
      pair <= entry_in.pair;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= entry_in.valid;
    end
  end

  // probe register, handed to the next cell every cycle
  always_ff @(posedge clk) begin
    probe.pair <= probe_in.pair;
    probe.hit  <= probe_in.hit | match;
  end

  assign entry_out.pair  = pair;
  assign entry_out.valid = valid;
  assign probe_out       = probe;
endmodule

/* rtl/core/seen_message_filter.sv */
// Duplicate filter for flooded message keys. Each request carries a sender key and a
// nonce and yields one verdict: duplicate is 1 when the pair is held in the history,
// 0 when it is new, in which case it is recorded as the newest entry and, once all
// HISTORY_DEPTH entries are in use, the oldest one is dropped. The history is a row
// of HISTORY_DEPTH cells; a lookup walks the row one cell per cycle, and no new
// request is taken until the scan has ended and its verdict is registered. The
// verdict sits in an output register, so a new request is taken while it waits.
// The history is empty after reset, with no clearing pass.
module seen_message_filter (
  input  logic               clk,
  input  logic               rst,
  smf_msg_if.sink            msg,
  smf_verdict_if.source      verdict
);
  import smf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [CNT_W-1:0] LAST_CELL = CNT_W'(HISTORY_DEPTH - 1);

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  pair_t            key;
  logic             out_valid;
  logic             out_dup;
  logic             take;
  logic             finish;
  logic             shift;

  probe_t probe_link [0:HISTORY_DEPTH];
  entry_t entry_link [0:HISTORY_DEPTH-1];

  // handshake and control decodes
  assign msg.ready = (state == ST_IDLE);
  assign take      = msg.valid && msg.ready;
  assign finish    = (state == ST_DONE) && (!out_valid || verdict.ready);
  assign shift     = finish && !probe_link[HISTORY_DEPTH].hit;

  // next state and scan counter
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        if (take) begin
          state_next = ST_SCAN;
          cnt_next   = '0;
        end
      end
      ST_SCAN: begin
        cnt_next = cnt + 1'b1;
        if (cnt == LAST_CELL) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // request key, held for the whole lookup and the insert
  always_ff @(posedge clk) begin
    if (take) begin
      key.sender_key    <= msg.sender_key;
      key.message_nonce <= msg.message_nonce;
    end
  end

  // probe fed into the head of the row; entries do not change during a scan, so every
  // probe of the held key that leaves the row before the insert carries the same hit
  assign probe_link[0].pair = key;
  assign probe_link[0].hit  = 1'b0;

  // new entry enters at the head, the oldest falls off the tail
  assign entry_link[0].pair  = key;
  assign entry_link[0].valid = 1'b1;

  // row of history cells
  for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_cell
    if (k < HISTORY_DEPTH - 1) begin : g_mid
      smf_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift     (shift),
        .entry_in  (entry_link[k]),
        .entry_out (entry_link[k+1]),
        .probe_in  (probe_link[k]),
        .probe_out (probe_link[k+1])
      );
    end else begin : g_tail
      smf_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift     (shift),
        .entry_in  (entry_link[k]),
        .entry_out (),
        .probe_in  (probe_link[k]),
        .probe_out (probe_link[k+1])
      );
    end
  end

  // verdict output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_dup <= probe_link[HISTORY_DEPTH].hit;
    end
  end

  assign verdict.valid     = out_valid;
  assign verdict.duplicate = out_dup;
endmodule
